### sv/base64_encoder_assert.svh
// assertion macros used by the base64 encoder back end
`ifndef BASE64_ENCODER_ASSERT_SVH
`define BASE64_ENCODER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define B64E_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define B64E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/b64e_pkg.sv
// shared types, constants and alphabet lookup of the base64 encoder
package b64e_pkg;

  // default number of entries in the job queue
  localparam int unsigned QueueDepthDefault = 2;

  // ascii '=' used for padding
  localparam logic [6:0] PadChar = 7'h3D;

  // one encoded job: up to four characters produced by one input byte
  typedef struct packed {
    logic            fin;   // job closes the message
    logic [1:0]      cnt;   // number of characters minus one
    logic [3:0]      pad;   // slot holds a pad character
    logic [3:0][5:0] sym;   // six-bit symbol of each slot
  } job_t;

  // six-bit symbol to ascii character of the standard alphabet
  function automatic logic [6:0] b64_char(input logic [5:0] s);
    logic [6:0] c;
    case (s) inside
      [6'd0:6'd25]:  c = {1'b0, s} + 7'h41;
      [6'd26:6'd51]: c = {1'b0, s} + 7'd71;
      [6'd52:6'd61]: c = {1'b0, s} - 7'd4;
      6'd62:         c = 7'h2B;
      default:       c = 7'h2F;
    endcase
    return c;
  endfunction

endpackage

### sv/b64e_front.sv
// front end: accepts bytes, tracks the group position and builds character jobs
module b64e_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     data_byte_i,
  input  logic           final_byte_i,
  input  logic           q_full_i,
  output logic           push_o,
  output b64e_pkg::job_t job_o
);

  typedef enum logic [1:0] {
    PhFirst,
    PhSecond,
    PhThird
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;

  // a byte is taken whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // split the byte into symbols for the current group position
  always_comb begin
    job_o     = '0;
    job_o.fin = final_byte_i;
    phase_d   = phase_q;
    left_d    = left_q;
    case (phase_q)
      PhSecond: begin
        job_o.sym[0] = {left_q[1:0], data_byte_i[7:4]};
        job_o.cnt    = 2'd0;
        left_d       = data_byte_i[3:0];
        phase_d      = PhThird;
        if (final_byte_i) begin
          job_o.sym[1] = {data_byte_i[3:0], 2'b00};
          job_o.pad[2] = 1'b1;
          job_o.cnt    = 2'd2;
        end
      end
      PhThird: begin
        job_o.sym[0] = {left_q, data_byte_i[7:6]};
        job_o.sym[1] = data_byte_i[5:0];
        job_o.cnt    = 2'd1;
        left_d       = 4'd0;
        phase_d      = PhFirst;
      end
      default: begin
        job_o.sym[0] = data_byte_i[7:2];
        job_o.cnt    = 2'd0;
        left_d       = {2'b00, data_byte_i[1:0]};
        phase_d      = PhSecond;
        if (final_byte_i) begin
          job_o.sym[1] = {data_byte_i[1:0], 4'b0000};
          job_o.pad[2] = 1'b1;
          job_o.pad[3] = 1'b1;
          job_o.cnt    = 2'd3;
        end
      end
    endcase
    // end of message restarts the group
    if (final_byte_i) begin
      phase_d = PhFirst;
      left_d  = 4'd0;
    end
  end

  // group position and leftover bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      left_q  <= 4'd0;
    end else if (push_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

### sv/b64e_queue.sv
// short job queue between the front and back ends
module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output b64e_pkg::job_t head_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64e_pkg::job_t store_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = store_q[rd_q];

  // pointer wrap and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_q] <= push_job_i;
    end
  end

endmodule

### sv/b64e_back.sv
// back end: walks each job and sends one character per transfer
`include "base64_encoder_assert.svh"

module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  b64e_pkg::job_t head_job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [6:0]     out_char_o,
  output logic           last_char_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [6:0] char_q;
  logic       last_q;
  logic       emit;
  logic       job_done;
  logic [6:0] char_next;

  // one character leaves the job whenever the output register is free
  assign emit      = head_valid_i && (!valid_q || out_ready_i);
  assign job_done  = (idx_q == head_job_i.cnt);
  assign pop_o     = emit && job_done;
  assign char_next = head_job_i.pad[idx_q] ? b64e_pkg::PadChar
                                           : b64e_pkg::b64_char(head_job_i.sym[idx_q]);

  // slot index and output valid
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (emit) begin
      idx_d   = job_done ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= char_next;
      last_q <= head_job_i.fin && job_done;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

  `B64E_ASSERT_NOW(a_idx_in_job, head_valid_i, idx_q <= head_job_i.cnt, "slot index past job end")
  `B64E_ASSERT_NOW(a_idx_rest, !head_valid_i, idx_q == 2'd0, "slot index not reset between jobs")
  `B64E_ASSERT_NEXT(a_last_sent, emit && job_done && head_job_i.fin, valid_q && last_q, "message end not flagged")

endmodule

### sv/base64_encoder.sv
// a byte accepted on the input passes through the job queue storage and the
// output character register before its first character is offered
// throughput: one byte accepted per cycle while the job queue has room
// the back end sends one character per cycle while the output is ready; a byte gives
// 1 to 4 characters (four per three-byte group, near 1.33 per byte on long messages)
// reset: asynchronous active low, clears group position, queue pointers and output valid
module base64_encoder #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // final_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [6:0] out_char, [7] zero fill
  output logic       m_axis_tlast_o    // last_char
);

  logic           q_full;
  logic           push;
  b64e_pkg::job_t push_job;
  logic           pop;
  logic           head_valid;
  b64e_pkg::job_t head_job;
  logic [6:0]     out_char;

  // byte intake and job build
  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .data_byte_i  (s_axis_tdata_i),
    .final_byte_i (s_axis_tlast_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  // decoupling queue
  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  // character output
  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_char_o   (out_char),
    .last_char_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, out_char};

endmodule
